// ===== hdl/key_adjusted_pwm_generator_top_assert.svh =====
// Assertion macros for the key adjusted PWM generator.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef KEY_ADJUSTED_PWM_GENERATOR_TOP_ASSERT_SVH
`define KEY_ADJUSTED_PWM_GENERATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KAPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kapg assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KAPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kapg assertion failed");

`endif

// ===== hdl/kapg_pkg.sv =====
// Shared types and constants of the key adjusted PWM generator.
// No dependencies; used by every module of the block.
package kapg_pkg;

    localparam int FREQ_W   = 4;
    localparam int DUTY_W   = 7;
    localparam int KEYS_W   = 4;
    localparam int TPS_W    = 27;
    localparam int TIME_W   = 32;
    localparam int NUM_W    = DUTY_W + TPS_W;
    localparam int DEN_W    = 11;
    localparam int DIV_CNT_W = 6;

    localparam int FREQ_RESET  = 1;
    localparam int DUTY_RESET  = 10;
    localparam int DUTY_STEP   = 7;
    localparam int DUTY_FULL   = 100;
    localparam int DUTY_TOP    = 99;
    localparam int DUTY_BOTTOM = 1;
    localparam int TPS_RESET   = 3000000;

    // First toggle time: the low time at the reset settings.
    localparam logic [TIME_W-1:0] NEXT_RESET =
        TIME_W'((DUTY_FULL - DUTY_RESET) * TPS_RESET / (DUTY_FULL * FREQ_RESET));

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Register index as decoded from paddr[2].
    localparam logic REG_TPS = 1'b0;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
    } t_setting;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [1:0] {
        S_CHECK,
        S_MUL,
        S_DIV,
        S_OUT
    } t_back_state;

endpackage

// ===== hdl/kapg_front.sv =====
// Front end: key edge detection and frequency / duty settings.
// Depends on kapg_pkg; feeds the settings queue.
module kapg_front #(
    parameter int MAX_FREQUENCY = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [kapg_pkg::KEYS_W-1:0]   i_keys,
    input  logic                          i_q_full,
    output logic                          o_q_wr,
    output kapg_pkg::t_setting            o_q_data
);

    logic [kapg_pkg::FREQ_W-1:0] r_freq, n_freq;
    logic [kapg_pkg::DUTY_W-1:0] r_duty, n_duty;
    logic [kapg_pkg::KEYS_W-1:0] r_prev_keys;
    logic [kapg_pkg::KEYS_W-1:0] w_rise;
    logic [kapg_pkg::FREQ_W:0]   w_f_inc;
    logic [kapg_pkg::DUTY_W:0]   w_d_inc;
    logic                        w_acc;

    assign w_acc = i_push && !i_q_full;

    // Edges apply in order: freq up, freq down, duty up, duty down.
    always_comb begin
        w_rise  = i_keys & ~r_prev_keys;
        w_f_inc = {1'b0, r_freq} + (kapg_pkg::FREQ_W+1)'(1);
        w_d_inc = {1'b0, r_duty} + (kapg_pkg::DUTY_W+1)'(kapg_pkg::DUTY_STEP);
        n_freq  = r_freq;
        n_duty  = r_duty;
        if (w_rise[0]) begin
            if (w_f_inc > (kapg_pkg::FREQ_W+1)'(MAX_FREQUENCY)) begin
                n_freq = kapg_pkg::FREQ_W'(MAX_FREQUENCY);
            end else begin
                n_freq = w_f_inc[kapg_pkg::FREQ_W-1:0];
            end
        end
        if (w_rise[1]) begin
            if (n_freq <= kapg_pkg::FREQ_W'(1)) begin
                n_freq = kapg_pkg::FREQ_W'(1);
            end else begin
                n_freq = n_freq - kapg_pkg::FREQ_W'(1);
            end
        end
        if (w_rise[2]) begin
            if (w_d_inc > (kapg_pkg::DUTY_W+1)'(kapg_pkg::DUTY_FULL)) begin
                n_duty = kapg_pkg::DUTY_W'(kapg_pkg::DUTY_TOP);
            end else begin
                n_duty = w_d_inc[kapg_pkg::DUTY_W-1:0];
            end
        end
        if (w_rise[3]) begin
            if (n_duty < kapg_pkg::DUTY_W'(kapg_pkg::DUTY_STEP)) begin
                n_duty = kapg_pkg::DUTY_W'(kapg_pkg::DUTY_BOTTOM);
            end else begin
                n_duty = n_duty - kapg_pkg::DUTY_W'(kapg_pkg::DUTY_STEP);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq      <= kapg_pkg::FREQ_W'(kapg_pkg::FREQ_RESET);
            r_duty      <= kapg_pkg::DUTY_W'(kapg_pkg::DUTY_RESET);
            r_prev_keys <= '0;
        end else if (w_acc) begin
            r_freq      <= n_freq;
            r_duty      <= n_duty;
            r_prev_keys <= i_keys;
        end
    end

    assign o_q_wr        = w_acc;
    assign o_q_data.freq = n_freq;
    assign o_q_data.duty = n_duty;

endmodule

// ===== hdl/kapg_fifo.sv =====
// Short settings queue between the front end and the toggle engine.
// Depends on kapg_pkg.
module kapg_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  kapg_pkg::t_setting  i_wr_data,
    input  logic                i_rd,
    output kapg_pkg::t_setting  o_rd_data,
    output kapg_pkg::t_q_stat   o_stat
);

    kapg_pkg::t_setting            r_mem [kapg_pkg::QUEUE_DEPTH];
    logic [kapg_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [kapg_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [kapg_pkg::QCNT_W-1:0]   r_count;
    logic                          w_wr;
    logic                          w_rd;

    assign o_stat.full  = (r_count == kapg_pkg::QCNT_W'(kapg_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_wr = i_wr && !o_stat.full;
    assign w_rd = i_rd && !o_stat.empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + kapg_pkg::QPTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + kapg_pkg::QPTR_W'(1);
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + kapg_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - kapg_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/kapg_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on kapg_pkg; used by the toggle engine for the span computation.
module kapg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [kapg_pkg::NUM_W-1:0]    i_num,
    input  logic [kapg_pkg::DEN_W-1:0]    i_den,
    output logic                          o_done,
    output logic [kapg_pkg::TIME_W-1:0]   o_quo
);

    logic [kapg_pkg::NUM_W-1:0]     r_q;
    logic [kapg_pkg::DEN_W-1:0]     r_rem;
    logic [kapg_pkg::DEN_W-1:0]     r_den;
    logic [kapg_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [kapg_pkg::DEN_W:0]       w_sh;
    logic [kapg_pkg::DEN_W:0]       w_diff;
    logic                           w_ge;

    // The remainder stays below the divisor, so the shifted value fits DEN_W+1 bits.
    always_comb begin
        w_sh   = {r_rem, r_q[kapg_pkg::NUM_W-1]};
        w_diff = w_sh - {1'b0, r_den};
        w_ge   = (w_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[kapg_pkg::DEN_W-1:0] : w_sh[kapg_pkg::DEN_W-1:0];
            r_q   <= {r_q[kapg_pkg::NUM_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= kapg_pkg::DIV_CNT_W'(kapg_pkg::NUM_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - kapg_pkg::DIV_CNT_W'(1);
            r_busy <= (r_cnt != kapg_pkg::DIV_CNT_W'(1));
            r_done <= (r_cnt == kapg_pkg::DIV_CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q[kapg_pkg::TIME_W-1:0];

endmodule

// ===== hdl/kapg_back.sv =====
// Toggle engine: tick counter, toggle compare, span computation, result register.
// Depends on kapg_pkg and kapg_div; reads settings from kapg_fifo.
module kapg_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kapg_pkg::t_setting            i_q_data,
    input  kapg_pkg::t_q_stat             i_q_stat,
    output logic                          o_q_rd,
    input  logic [kapg_pkg::TPS_W-1:0]    i_tps,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic                          o_pin_level,
    output logic [kapg_pkg::FREQ_W-1:0]   o_frequency_hz,
    output logic [kapg_pkg::DUTY_W-1:0]   o_duty_hundredths
);

    kapg_pkg::t_back_state          r_state, n_state;
    logic [kapg_pkg::TIME_W-1:0]    r_tick;
    logic [kapg_pkg::TIME_W-1:0]    r_next;
    logic                           r_level;
    logic [kapg_pkg::FREQ_W-1:0]    r_freq;
    logic [kapg_pkg::DUTY_W-1:0]    r_duty;
    logic                           r_out_vld;
    logic                           r_out_level;
    logic [kapg_pkg::FREQ_W-1:0]    r_out_freq;
    logic [kapg_pkg::DUTY_W-1:0]    r_out_duty;

    logic [kapg_pkg::TIME_W-1:0]    w_diff;
    logic                           w_toggle;
    logic                           w_have;
    logic                           w_out_free;
    logic                           w_load_out;
    logic                           w_div_start;
    logic [kapg_pkg::DUTY_W-1:0]    w_h;
    logic [kapg_pkg::FREQ_W-1:0]    w_f_eff;
    logic [kapg_pkg::NUM_W-1:0]     w_prod;
    logic [kapg_pkg::DEN_W-1:0]     w_den;
    logic                           w_div_done;
    logic [kapg_pkg::TIME_W-1:0]    w_quo;

    always_comb begin
        w_diff     = r_tick - r_next;
        w_toggle   = (w_diff != '0) && !w_diff[kapg_pkg::TIME_W-1];
        w_have     = !i_q_stat.empty;
        w_out_free = !r_out_vld || i_pop;
    end

    // A low pin needs the high time next, a high pin the low time.
    always_comb begin
        if (!r_level) begin
            w_h = r_duty;
        end else if (r_duty > kapg_pkg::DUTY_W'(kapg_pkg::DUTY_FULL)) begin
            w_h = '0;
        end else begin
            w_h = kapg_pkg::DUTY_W'(kapg_pkg::DUTY_FULL) - r_duty;
        end
        w_f_eff = (r_freq == '0) ? kapg_pkg::FREQ_W'(1) : r_freq;
        w_prod  = kapg_pkg::NUM_W'(w_h) * kapg_pkg::NUM_W'(i_tps);
        w_den   = kapg_pkg::DEN_W'(w_f_eff) * kapg_pkg::DEN_W'(kapg_pkg::DUTY_FULL);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kapg_pkg::S_CHECK: begin
                if (w_have && w_toggle) begin
                    n_state = kapg_pkg::S_MUL;
                end
            end
            kapg_pkg::S_MUL: begin
                n_state = kapg_pkg::S_DIV;
            end
            kapg_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = kapg_pkg::S_OUT;
                end
            end
            kapg_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = kapg_pkg::S_CHECK;
                end
            end
            default: n_state = kapg_pkg::S_CHECK;
        endcase
    end

    always_comb begin
        o_q_rd      = 1'b0;
        w_load_out  = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            kapg_pkg::S_CHECK: begin
                o_q_rd     = w_have && (w_toggle || w_out_free);
                w_load_out = w_have && !w_toggle && w_out_free;
            end
            kapg_pkg::S_MUL: begin
                w_div_start = 1'b1;
            end
            kapg_pkg::S_DIV: begin
                w_load_out = 1'b0;
            end
            kapg_pkg::S_OUT: begin
                w_load_out = w_out_free;
            end
            default: begin
                o_q_rd = 1'b0;
            end
        endcase
    end

    kapg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_freq <= i_q_data.freq;
            r_duty <= i_q_data.duty;
        end
        if (w_load_out) begin
            r_out_level <= r_level;
            if (r_state == kapg_pkg::S_CHECK) begin
                r_out_freq <= i_q_data.freq;
                r_out_duty <= i_q_data.duty;
            end else begin
                r_out_freq <= r_freq;
                r_out_duty <= r_duty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kapg_pkg::S_CHECK;
            r_tick    <= '0;
            r_next    <= kapg_pkg::NEXT_RESET;
            r_level   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_q_rd) begin
                r_tick <= r_tick + kapg_pkg::TIME_W'(1);
            end
            if ((r_state == kapg_pkg::S_DIV) && w_div_done) begin
                r_next  <= r_next + w_quo;
                r_level <= !r_level;
            end
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_empty           = !r_out_vld;
    assign o_pin_level       = r_out_level;
    assign o_frequency_hz    = r_out_freq;
    assign o_duty_hundredths = r_out_duty;

endmodule

// ===== hdl/key_adjusted_pwm_generator_top.sv =====
// Key adjusted PWM generator: configuration port, front end, queue, toggle engine.
// Depends on kapg_pkg, kapg_front, kapg_fifo, kapg_back and the assertion header.
//
// Usage: every transaction on the input queue port (push/full) is one timer tick
// carrying four key levels. Each tick yields exactly one transaction on the
// result queue port (empty/pop): pin level, frequency and duty after that tick.
// The APB port holds ticks_per_second at address 0; write it only while idle.
// A tick that does not toggle the pin is popped from the queue and loaded into
// the result register at the same edge. A tick that toggles the pin passes
// through the toggle engine: span product, then the one-bit-per-cycle divider
// (34 quotient bits and its done flag), then the result load. Throughput is one
// tick per cycle between toggles while the receiver pops; the divider sets
// the cost of each toggle. A four-entry queue lets the front end keep taking
// ticks while the divider runs. Reset (synchronous) restores 1 Hz, duty 10, tick
// count zero, pin low and the first toggle time; both queues come out empty.
// When the receiver stalls, the result register holds, then the queue fills and
// full rises.
module key_adjusted_pwm_generator_top #(
    parameter int MAX_FREQUENCY = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [kapg_pkg::KEYS_W-1:0]   i_keys,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_pin_level,
    output logic [kapg_pkg::FREQ_W-1:0]   o_frequency_hz,
    output logic [kapg_pkg::DUTY_W-1:0]   o_duty_hundredths,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [kapg_pkg::TPS_W-1:0] r_tps;
    logic                       w_cfg_wr;
    logic                       w_q_wr;
    logic                       w_q_rd;
    kapg_pkg::t_setting         w_q_wdata;
    kapg_pkg::t_setting         w_q_rdata;
    kapg_pkg::t_q_stat          w_q_stat;
    logic                       w_freq_ok;
    logic                       w_duty_ok;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == kapg_pkg::REG_TPS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= kapg_pkg::TPS_W'(kapg_pkg::TPS_RESET);
        end else if (w_cfg_wr) begin
            r_tps <= pwdata[kapg_pkg::TPS_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == kapg_pkg::REG_TPS) begin
            prdata = 32'(r_tps);
        end else begin
            prdata = '0;
        end
    end

    assign full = w_q_stat.full;

    kapg_front #(
        .MAX_FREQUENCY (MAX_FREQUENCY)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_keys   (i_keys),
        .i_q_full (w_q_stat.full),
        .o_q_wr   (w_q_wr),
        .o_q_data (w_q_wdata)
    );

    kapg_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_q_wr),
        .i_wr_data (w_q_wdata),
        .i_rd      (w_q_rd),
        .o_rd_data (w_q_rdata),
        .o_stat    (w_q_stat)
    );

    kapg_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_data          (w_q_rdata),
        .i_q_stat          (w_q_stat),
        .o_q_rd            (w_q_rd),
        .i_tps             (r_tps),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_pin_level       (o_pin_level),
        .o_frequency_hz    (o_frequency_hz),
        .o_duty_hundredths (o_duty_hundredths)
    );

    assign w_freq_ok = (o_frequency_hz >= kapg_pkg::FREQ_W'(1)) &&
                       (o_frequency_hz <= kapg_pkg::FREQ_W'(MAX_FREQUENCY));
    assign w_duty_ok = (o_duty_hundredths >= kapg_pkg::DUTY_W'(kapg_pkg::DUTY_BOTTOM)) &&
                       (o_duty_hundredths <= kapg_pkg::DUTY_W'(kapg_pkg::DUTY_TOP));

`include "key_adjusted_pwm_generator_top_assert.svh"

    // An accepted tick always leaves at least one entry in the settings queue.
    `KAPG_ASSERT_NEXT(a_queue_filled, push && !full, !w_q_stat.empty)
    `KAPG_ASSERT_NOW(a_freq_range, !empty, w_freq_ok)
    `KAPG_ASSERT_NOW(a_duty_range, !empty, w_duty_ok)

endmodule

// ===== tb/key_adjusted_pwm_generator_top_tb.sv =====
// Self-checking testbench for the key adjusted PWM generator top level.
// Depends on kapg_pkg and key_adjusted_pwm_generator_top; a built-in model predicts results.
`timescale 1ns / 1ps

module key_adjusted_pwm_generator_top_tb;

    localparam int MAX_FREQ      = 10;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [kapg_pkg::KEYS_W-1:0] KEY_NONE      = '0;
    localparam logic [kapg_pkg::KEYS_W-1:0] KEY_FREQ_UP   = 4'b0001;
    localparam logic [kapg_pkg::KEYS_W-1:0] KEY_FREQ_DOWN = 4'b0010;
    localparam logic [kapg_pkg::KEYS_W-1:0] KEY_DUTY_UP   = 4'b0100;
    localparam logic [kapg_pkg::KEYS_W-1:0] KEY_DUTY_DOWN = 4'b1000;
    localparam logic [kapg_pkg::KEYS_W-1:0] KEY_ALL       = '1;

    localparam logic [2:0] ADDR_RATE   = {kapg_pkg::REG_TPS, 2'b00};
    localparam logic [2:0] ADDR_UNUSED = {~kapg_pkg::REG_TPS, 2'b00};

    typedef struct {
        logic                        level;
        logic [kapg_pkg::FREQ_W-1:0] freq;
        logic [kapg_pkg::DUTY_W-1:0] duty;
    } t_pwm_status;

    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        push    = 1'b0;
    logic                        full;
    logic [kapg_pkg::KEYS_W-1:0] i_keys  = '0;
    logic                        empty;
    logic                        pop     = 1'b0;
    logic                        o_pin_level;
    logic [kapg_pkg::FREQ_W-1:0] o_frequency_hz;
    logic [kapg_pkg::DUTY_W-1:0] o_duty_hundredths;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [2:0]                  paddr   = '0;
    logic [31:0]                 pwdata  = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // Model of the generator state.
    int                          freq_model;
    int                          duty_model;
    logic [kapg_pkg::KEYS_W-1:0] keys_prev_model;
    logic [kapg_pkg::TIME_W-1:0] tick_model;
    logic [kapg_pkg::TIME_W-1:0] toggle_at_model;
    logic                        level_model;
    logic [kapg_pkg::TPS_W-1:0]  tps_model;

    t_pwm_status pending_status_q[$];
    t_pwm_status oldest_status;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int ticks_sent    = 0;
    int results_seen  = 0;
    int rate_writes   = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    key_adjusted_pwm_generator_top #(
        .MAX_FREQUENCY(MAX_FREQ)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_keys           (i_keys),
        .empty            (empty),
        .pop              (pop),
        .o_pin_level      (o_pin_level),
        .o_frequency_hz   (o_frequency_hz),
        .o_duty_hundredths(o_duty_hundredths),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[key_adjusted_pwm_generator_top] ERROR");
            $finish;
        end
    end

    function automatic logic [kapg_pkg::TIME_W-1:0] span_in_ticks(input int hundredths,
                                                                  input int freq);
        logic [63:0] product;
        product = 64'(hundredths) * 64'(tps_model);
        return kapg_pkg::TIME_W'(product / (64'd100 * 64'(freq)));
    endfunction

    function automatic void reset_pwm_model();
        tps_model       = kapg_pkg::TPS_W'(kapg_pkg::TPS_RESET);
        freq_model      = kapg_pkg::FREQ_RESET;
        duty_model      = kapg_pkg::DUTY_RESET;
        keys_prev_model = '0;
        tick_model      = '0;
        level_model     = 1'b0;
        toggle_at_model = span_in_ticks(kapg_pkg::DUTY_FULL - kapg_pkg::DUTY_RESET,
                                        kapg_pkg::FREQ_RESET);
    endfunction

    function automatic t_pwm_status step_pwm_model(input logic [kapg_pkg::KEYS_W-1:0] keys);
        logic [kapg_pkg::KEYS_W-1:0] rise;
        logic [kapg_pkg::TIME_W-1:0] high_ticks;
        logic [kapg_pkg::TIME_W-1:0] low_ticks;
        logic [kapg_pkg::TIME_W-1:0] lag;
        t_pwm_status                 status;
        rise = keys & ~keys_prev_model;
        // Simultaneous edges apply in order: freq up, freq down, duty up, duty down.
        if (|(rise & KEY_FREQ_UP)) begin
            freq_model = (freq_model >= MAX_FREQ) ? MAX_FREQ : freq_model + 1;
        end
        if (|(rise & KEY_FREQ_DOWN)) begin
            freq_model = (freq_model <= 1) ? 1 : freq_model - 1;
        end
        if (|(rise & KEY_DUTY_UP)) begin
            duty_model = (duty_model + kapg_pkg::DUTY_STEP > kapg_pkg::DUTY_FULL) ?
                         kapg_pkg::DUTY_TOP : duty_model + kapg_pkg::DUTY_STEP;
        end
        if (|(rise & KEY_DUTY_DOWN)) begin
            duty_model = (duty_model - kapg_pkg::DUTY_STEP < 0) ?
                         kapg_pkg::DUTY_BOTTOM : duty_model - kapg_pkg::DUTY_STEP;
        end
        keys_prev_model = keys;

        high_ticks = span_in_ticks(duty_model, freq_model);
        low_ticks  = span_in_ticks(kapg_pkg::DUTY_FULL - duty_model, freq_model);

        // The pin toggles only once the counter is strictly past the toggle time.
        lag = tick_model - toggle_at_model;
        if (lag != '0 && !lag[kapg_pkg::TIME_W-1]) begin
            if (!level_model) begin
                toggle_at_model = toggle_at_model + high_ticks;
                level_model     = 1'b1;
            end else begin
                toggle_at_model = toggle_at_model + low_ticks;
                level_model     = 1'b0;
            end
        end
        tick_model = tick_model + 1'b1;

        status.level = level_model;
        status.freq  = kapg_pkg::FREQ_W'(freq_model);
        status.duty  = kapg_pkg::DUTY_W'(duty_model);
        return status;
    endfunction

    // Result side: random pops, plus a long hold-off whenever hold_req moves.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                results_seen++;
                if (pending_status_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result: pin %0b freq %0d duty %0d",
                             $time, o_pin_level, o_frequency_hz, o_duty_hundredths);
                end else begin
                    oldest_status = pending_status_q.pop_front();
                    if (o_pin_level !== oldest_status.level ||
                        o_frequency_hz !== oldest_status.freq ||
                        o_duty_hundredths !== oldest_status.duty) begin
                        error_count++;
                        $display({"%0t: expected pin %0b freq %0d duty %0d, ",
                                  "got pin %0b freq %0d duty %0d"},
                                 $time, oldest_status.level, oldest_status.freq,
                                 oldest_status.duty, o_pin_level, o_frequency_hz,
                                 o_duty_hundredths);
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // One tick transaction; push stays high so back-to-back ticks need no gap.
    task automatic send_tick(input logic [kapg_pkg::KEYS_W-1:0] keys);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_keys <= keys;
        do @(posedge i_clk); while (full);
        pending_status_q.push_back(step_pwm_model(keys));
        ticks_sent++;
    endtask

    task automatic wait_until_drained();
        push <= 1'b0;
        while (pending_status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register, then read the rate back through the same port.
    task automatic program_rate(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_RATE) begin
            tps_model = value[kapg_pkg::TPS_W-1:0];
        end
        rate_writes++;

        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_RATE;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(tps_model)) begin
            error_count++;
            $display("%0t: rate read back: expected %0d, got %0d", $time, tps_model, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_directed_keys();
        logic [kapg_pkg::KEYS_W-1:0] pattern[$];
        send_idle_pct = 37;
        recv_idle_pct = 53;
        pattern = '{KEY_NONE, KEY_ALL, KEY_NONE, KEY_FREQ_DOWN, KEY_NONE,
                    KEY_DUTY_DOWN, KEY_NONE, KEY_DUTY_DOWN, KEY_NONE, KEY_FREQ_UP,
                    KEY_FREQ_UP | KEY_DUTY_UP, KEY_FREQ_UP | KEY_DUTY_UP, KEY_NONE,
                    KEY_FREQ_UP | KEY_FREQ_DOWN, KEY_DUTY_UP | KEY_DUTY_DOWN,
                    KEY_DUTY_UP, KEY_NONE, KEY_DUTY_UP, KEY_NONE, KEY_ALL, KEY_ALL,
                    KEY_FREQ_DOWN, KEY_NONE};
        foreach (pattern[i]) begin
            send_tick(pattern[i]);
        end
    endtask

    task automatic run_rate_phase(input logic [2:0] addr, input logic [31:0] value);
        wait_until_drained();
        program_rate(addr, value);
        repeat (8) send_tick(kapg_pkg::KEYS_W'($urandom_range(15)));
    endtask

    task automatic test_rate_register();
        send_idle_pct = 37;
        recv_idle_pct = 53;
        run_rate_phase(ADDR_RATE, 32'd0);
        run_rate_phase(ADDR_RATE, 32'hFFFF_FFFF);
        // A write to the unused address must leave the rate untouched.
        run_rate_phase(ADDR_UNUSED, 32'h0000_1234);
        run_rate_phase(ADDR_RATE, 32'd1);
        run_rate_phase(ADDR_RATE, 32'h0555_5555);
    endtask

    // Mostly press/release bursts on one key, so the clamps get reached.
    task automatic test_random_keys(input int sender_gap_pct, input int receiver_gap_pct,
                                    input logic [31:0] rate, input int tick_target);
        int                          stop_at;
        int                          key_bit;
        int                          presses;
        logic [kapg_pkg::KEYS_W-1:0] keys;
        wait_until_drained();
        program_rate(ADDR_RATE, rate);
        send_idle_pct = sender_gap_pct;
        recv_idle_pct = receiver_gap_pct;
        stop_at = ticks_sent + tick_target;
        while (ticks_sent < stop_at) begin
            if ($urandom_range(99) < 70) begin
                key_bit = $urandom_range(kapg_pkg::KEYS_W - 1);
                presses = $urandom_range(12, 1);
                repeat (presses) begin
                    keys = kapg_pkg::KEYS_W'(1) << key_bit;
                    if ($urandom_range(9) == 0) begin
                        keys = keys | kapg_pkg::KEYS_W'($urandom_range(15));
                    end
                    repeat ($urandom_range(3, 1)) send_tick(keys);
                    repeat ($urandom_range(2, 1)) send_tick(KEY_NONE);
                end
            end else begin
                repeat ($urandom_range(4, 1)) send_tick(kapg_pkg::KEYS_W'($urandom_range(15)));
            end
        end
    endtask

    // The receiver stops for a long stretch while ticks keep coming.
    task automatic test_result_stall();
        wait_until_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = hold_req + 1;
        repeat (60) send_tick(kapg_pkg::KEYS_W'($urandom_range(15)));
    endtask

    initial begin
        reset_pwm_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_keys();
        test_rate_register();
        test_random_keys(37, 53, 32'd1000, 150);
        test_random_keys(53, 37, 32'd100000000, 150);
        test_random_keys(0, 0, 32'($urandom_range(32'h07FF_FFFF)), 150);
        test_result_stall();
        wait_until_drained();

        if (pending_status_q.size() != 0) begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, pending_status_q.size());
        end
        $display("Sent %0d ticks and checked %0d results over %0d register writes,",
                 ticks_sent, results_seen, rate_writes);
        $display("covering key edges and clamps, zero and full-scale rates and a result stall.");
        if (error_count == 0) begin
            $display("[key_adjusted_pwm_generator_top] OK");
        end else begin
            $display("[key_adjusted_pwm_generator_top] ERROR");
        end
        $finish;
    end

endmodule
